// ===== hdl/b2da_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII unit.
// No dependencies; used by b2da_ctrl, b2da_dpath and the top level.
`default_nettype none

package b2da_pkg;

  localparam int unsigned IN_W       = 64;  // width of the input value port
  localparam int unsigned DIGIT_W    = 4;   // one BCD digit
  localparam int unsigned CHAR_W     = 6;   // ASCII digit code width
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture a new value, clear the BCD field
    logic shift;    // one double-dabble step
    logic advance;  // drop the top digit, bring up the next one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic top_zero; // most significant BCD digit is zero
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/binary_to_decimal_ascii_unit.sv =====
// Binary to decimal ASCII unit, top level: controller plus datapath.
// Depends on b2da_pkg, b2da_ctrl, b2da_dpath.
//
// Sequence: accept the value, run the bit-serial double-dabble shift loop, skip
// leading zeros one digit a cycle, then send the digits one per cycle while out_ready.
// A new value is accepted only after the last digit word of the previous one is taken.
// Reset (rst_n low, synchronous) returns the controller to idle; data regs are not reset.
`default_nettype none

module binary_to_decimal_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire logic [b2da_pkg::IN_W-1:0]      in_value,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                                out_last
);

  // decimal digits needed for VALUE_WIDTH bits: floor(W*log10(2)) + 1
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;

  b2da_pkg::cmd_t              cmd;
  b2da_pkg::status_t           status;
  logic [b2da_pkg::DIGIT_W-1:0] top_digit;

  // FSM: idle -> convert (one bit a cycle) -> skip zeros -> emit words
  b2da_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (out_last),
    .cmd       (cmd),
    .status    (status)
  );

  // shift registers; the top BCD digit is always the next word to send
  b2da_dpath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dpath (
    .clk       (clk),
    .in_value  (in_value),
    .cmd       (cmd),
    .status    (status),
    .top_digit (top_digit)
  );

  // digit to ASCII: '0' plus the BCD value, straight from a register
  assign out_digit_char = b2da_pkg::ASCII_ZERO
                        + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, top_digit};

endmodule

`default_nettype wire

// ===== hdl/b2da_dpath.sv =====
// Datapath: binary shift register and BCD digit field for double dabble.
// Depends on b2da_pkg.
`default_nettype none

module b2da_dpath #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned NUM_DIGITS  = 20
) (
  input  wire                                clk,
  input  wire logic [b2da_pkg::IN_W-1:0]     in_value,
  input  wire b2da_pkg::cmd_t                cmd,
  output b2da_pkg::status_t                  status,
  output logic [b2da_pkg::DIGIT_W-1:0]       top_digit
);

  localparam int unsigned BCD_W = NUM_DIGITS * b2da_pkg::DIGIT_W;
  localparam int unsigned DW    = b2da_pkg::DIGIT_W;

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_corr;

  // add-3 correction, each digit on its own
  always_comb begin
    for (int g = 0; g < NUM_DIGITS; g++) begin
      if (bcd_r[g*DW +: DW] >= 4'd5) begin
        bcd_corr[g*DW +: DW] = bcd_r[g*DW +: DW] + 4'd3;
      end else begin
        bcd_corr[g*DW +: DW] = bcd_r[g*DW +: DW];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (cmd.load) begin
      bin_nxt = in_value[VALUE_WIDTH-1:0];
      bcd_nxt = '0;
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_corr[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.advance) begin
      bcd_nxt = {bcd_r[BCD_W-DW-1:0], {DW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign top_digit       = bcd_r[BCD_W-1 -: DW];
  assign status.top_zero = (top_digit == '0);

endmodule

`default_nettype wire

// ===== hdl/b2da_ctrl.sv =====
// Controller FSM: sequences conversion, leading-zero skip and digit output.
// Depends on b2da_pkg.
`default_nettype none

module b2da_ctrl #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned NUM_DIGITS  = 20
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                last,
  output b2da_pkg::cmd_t      cmd,
  input  wire b2da_pkg::status_t status
);

  localparam int unsigned BC_W = $clog2(VALUE_WIDTH);
  localparam int unsigned DC_W = $clog2(NUM_DIGITS + 1);
  localparam logic [BC_W-1:0] BIT_LAST  = BC_W'(VALUE_WIDTH - 1);
  localparam logic [DC_W-1:0] DIG_FULL  = DC_W'(NUM_DIGITS);
  localparam logic [DC_W-1:0] DIG_ONE   = DC_W'(1);

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_SKIP, S_EMIT} state_t;

  state_t          state_r, state_nxt;
  logic [BC_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DC_W-1:0] dig_cnt_r, dig_cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign last      = (dig_cnt_r == DIG_ONE);

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = '0;
          dig_cnt_nxt = DIG_FULL;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift   = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_LAST) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // strip leading zeros, keep at least one digit
        if (status.top_zero && !last) begin
          cmd.advance = 1'b1;
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            dig_cnt_nxt = dig_cnt_r - 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      bit_cnt_r <= '0;
      dig_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      dig_cnt_r <= dig_cnt_nxt;
    end
  end

  a_ready_xor_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("in_ready while a word is pending");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("conversion did not start after accept");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("input not ready after final word");

  a_digits_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !last) |=> (out_valid && dig_cnt_r != '0))
    else $error("gap or count underflow inside a digit run");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for binary_to_decimal_ascii_unit: random and directed 64-bit values,
// with digit words checked against a built-in decimal conversion.
// Depends on b2da_pkg and the RTL of the unit; needs no other files.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_W     = 64;      // must match the uut parameter
  localparam int unsigned MAX_DIGITS  = 20;      // 2**64-1 has 20 decimal digits
  localparam int unsigned N_RANDOM    = 480;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_AT     = 1500;    // word count where the long stall starts
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned DRAIN_CYCLES = 120;    // more than one full conversion

  // One expected digit word: ASCII code plus the end-of-number flag.
  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } digit_word_t;

  // Expected digit words, oldest first, plus the counts for the summary.
  class digit_scoreboard;
    digit_word_t pending_q[$];
    int unsigned n_values;
    int unsigned n_words;
    int unsigned n_errors;
    int unsigned longest;

    function new();
      n_values = 0;
      n_words  = 0;
      n_errors = 0;
      longest  = 0;
    endfunction

    // Decimal text of an accepted value, most significant digit first.
    function void note_value(logic [b2da_pkg::IN_W-1:0] raw);
      logic [VALUE_W-1:0] v;
      logic [3:0]         dig [MAX_DIGITS];
      int unsigned        n;
      digit_word_t        w;
      v = raw[VALUE_W-1:0];
      n = 0;
      do begin
        dig[n] = 4'(v % 10);
        v = v / 10;
        n++;
      end while (v != 0 && n < MAX_DIGITS);
      for (int k = n - 1; k >= 0; k--) begin
        w.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(dig[k]);
        w.last = (k == 0);
        pending_q.push_back(w);
      end
      n_values++;
      if (n > longest) longest = n;
    endfunction

    function void report(string what, digit_word_t exp_w,
                         logic [b2da_pkg::CHAR_W-1:0] ch, logic last);
      n_errors++;
      if (n_errors <= 10)
        $display("%0t mismatch (%s): expected char %0d last %0b, got char %0d last %0b",
                 $realtime, what, exp_w.ch, exp_w.last, ch, last);
    endfunction

    function void check_word(logic [b2da_pkg::CHAR_W-1:0] ch, logic last);
      digit_word_t exp_w;
      if (pending_q.size() == 0) begin
        exp_w = '0;
        report("no digit pending", exp_w, ch, last);
        return;
      end
      exp_w = pending_q.pop_front();
      n_words++;
      if (ch !== exp_w.ch || last !== exp_w.last)
        report("digit word", exp_w, ch, last);
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [b2da_pkg::IN_W-1:0]   in_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [b2da_pkg::CHAR_W-1:0] out_digit_char;
  logic                        out_last;

  digit_scoreboard sb;
  int unsigned     cycles;
  bit              calm_phase;   // both sides run without idling while set

  binary_to_decimal_ascii_unit #(
    .VALUE_WIDTH(VALUE_W)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles, sb.pending());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor: every word that crosses a channel is seen here, at the edge that
  // accepts it, before any of this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_value(in_value);
      if (out_valid && out_ready) sb.check_word(out_digit_char, out_last);
    end
  end

  // Offer one value after an idle gap that may be empty; returns at the edge that accepts it.
  // in_valid is left high so a back-to-back value needs no second update.
  task automatic send_value(input logic [b2da_pkg::IN_W-1:0] v);
    int unsigned gap;
    gap = calm_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_value <= {$urandom, $urandom};   // junk while idle
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Value mix for the random part: full-width numbers, numbers of every length,
  // values around powers of ten, zero and single digits, and values near the top.
  function automatic logic [b2da_pkg::IN_W-1:0] pick_value();
    logic [b2da_pkg::IN_W-1:0] v;
    logic [b2da_pkg::IN_W-1:0] p;
    int unsigned               k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5, 6: v = v >> $urandom_range(1, 63);
      7: begin
        p = 1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * 10;
        v = p + b2da_pkg::IN_W'($urandom_range(0, 2)) - 1;
      end
      8: v = b2da_pkg::IN_W'($urandom_range(0, 9));
      default: v = ~b2da_pkg::IN_W'($urandom_range(0, 1000));
    endcase
    return v;
  endfunction

  // Receiver: random stalls per word, one long stall so the unit backs up.
  initial begin : receiver
    int unsigned gap;
    int unsigned n_rx;
    bit          held;
    n_rx = 0;
    held = 0;
    out_ready = 1'b0;
    @(posedge clk);
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = calm_phase ? 0 : $urandom_range(0, 3);
      if (!held && n_rx >= HOLD_AT) begin
        // sender keeps offering meanwhile, so in_ready has to drop
        held = 1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_rx++;
    end
  end

  initial begin : stimulus
    logic [b2da_pkg::IN_W-1:0] directed [$];
    logic [b2da_pkg::IN_W-1:0] p;
    int unsigned               waited;
    sb         = new();
    cycles     = 0;
    calm_phase = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_value   = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero, one- and two-digit edges, 19 vs 20 digits, the extremes
    // and bit patterns that flip every bit of the input.
    p = 1;
    repeat (19) p = p * 10;
    directed = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                 p - 1, p, p + 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                 64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000,
                 64'd1234567890, 64'd1000000000000, 64'd0};
    foreach (directed[i]) send_value(directed[i]);

    // Random: blocks of 60 values, now and then a block with no idling at all.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 60 == 0) calm_phase = ($urandom_range(0, 3) == 0);
      send_value(pick_value());
    end
    in_valid  <= 1'b0;
    calm_phase = 0;

    // let the monitor log the last accepted value before counting what is left
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    // catch any stray word after the last expected one
    for (waited = 0; waited < DRAIN_CYCLES; waited++) @(posedge clk);

    $display("converted %0d values into %0d digit words, longest number %0d digits",
             sb.n_values, sb.n_words, sb.longest);
    $display("mismatches: %0d, cycles: %0d", sb.n_errors, cycles);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/b2da_pkg.sv
hdl/b2da_dpath.sv
hdl/b2da_ctrl.sv
hdl/binary_to_decimal_ascii_unit.sv
test/tb_top.sv
